### rtl/core/hmbs_pkg.sv
// Shared types and constants for histogram mode background subtraction.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package hmbs_pkg;

    localparam int unsigned VOX_W      = 8;
    localparam int unsigned NUM_BINS   = 256;
    localparam int unsigned BIN_ADDR_W = $clog2(NUM_BINS);
    localparam longint unsigned MAX_VOXELS = 64'd16777216;
    localparam int unsigned BIN_W      = $clog2(MAX_VOXELS + 64'd1);

    typedef logic [VOX_W-1:0]      t_vox;
    typedef logic [BIN_ADDR_W-1:0] t_bin_addr;
    typedef logic [BIN_W-1:0]      t_bin;

    localparam t_bin BIN_MAX = '1;

    // Histogram memory request from the controller.
    typedef struct packed {
        t_bin_addr rd_addr;
        logic      wr_en;
        t_bin_addr wr_addr;
        t_bin      wr_data;
        logic      clr_all;
    } t_mem_req;

    // Histogram memory response, in the cycle after the read address.
    typedef struct packed {
        t_bin rd_cnt;
    } t_mem_rsp;

endpackage

`default_nettype wire

### rtl/core/hmbs_if.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on hmbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hmbs_in_if;
    import hmbs_pkg::*;
    logic valid;
    logic ready;
    logic kind;
    t_vox voxel;
    logic last_voxel;

    modport source (output valid, output kind, output voxel, output last_voxel, input ready);
    modport sink   (input valid, input kind, input voxel, input last_voxel, output ready);
endinterface

interface hmbs_out_if;
    import hmbs_pkg::*;
    logic valid;
    logic ready;
    t_vox pixel_out;
    logic last_out;

    modport source (output valid, output pixel_out, output last_out, input ready);
    modport sink   (input valid, input pixel_out, input last_out, output ready);
endinterface

`default_nettype wire

### rtl/core/hmbs_bin_mem.sv
// Histogram bin memory: 256 x 25 synchronous RAM, registered read,
// with per-entry valid flops so reset and clear-all take effect at once.
// Depends on hmbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hmbs_bin_mem (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  hmbs_pkg::t_mem_req  i_req,
    output hmbs_pkg::t_mem_rsp  o_rsp
);
    import hmbs_pkg::*;

    t_bin                r_mem [NUM_BINS];
    logic [NUM_BINS-1:0] r_valid;
    t_bin                r_rd_data;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[i_req.rd_addr];
            if (i_req.clr_all) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    // An entry never written since the last clear reads as zero.
    assign o_rsp.rd_cnt = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

### rtl/core/hmbs_hist_ctrl.sv
// Histogram controller: count-pass read-modify-write with forwarding,
// then the mode scan over all bins. Depends on hmbs_pkg and hmbs_bin_mem.
`timescale 1ns / 1ps
`default_nettype none

module hmbs_hist_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cnt_acc,
    input  hmbs_pkg::t_vox      i_voxel,
    input  wire                 i_last,
    output logic                o_busy,
    output hmbs_pkg::t_vox      o_mode
);
    import hmbs_pkg::*;

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;

    t_mem_req req;
    t_mem_rsp rsp;

    logic [1:0]        r_st, n_st;
    logic              r_s1_vld;
    t_bin_addr         r_s1_addr;
    logic              r_fw_vld;
    t_bin_addr         r_fw_addr;
    t_bin              r_fw_data;
    logic [BIN_ADDR_W:0] r_scan_addr;
    logic              r_sc_vld;
    t_bin_addr         r_sc_idx;
    t_bin              r_best;
    t_bin_addr         r_best_idx;
    t_vox              r_mode;

    t_bin      cur_cnt;
    t_bin      new_cnt;
    logic      scan_issue;
    logic      take;
    t_bin_addr n_best_idx;
    logic      scan_done;

    hmbs_bin_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // Count stage: forward the previous write when it hit the same bin.
    always_comb begin
        cur_cnt = (r_fw_vld && (r_fw_addr == r_s1_addr)) ? r_fw_data : rsp.rd_cnt;
        new_cnt = (cur_cnt == BIN_MAX) ? cur_cnt : cur_cnt + t_bin'(1);
    end

    assign scan_issue = (r_st == ST_SCAN) && !r_scan_addr[BIN_ADDR_W];
    assign take       = r_sc_vld && ((r_sc_idx == '0) || (rsp.rd_cnt > r_best));
    assign n_best_idx = take ? r_sc_idx : r_best_idx;
    assign scan_done  = r_sc_vld && (r_sc_idx == t_bin_addr'(NUM_BINS - 1));

    always_comb begin
        req.rd_addr = scan_issue ? r_scan_addr[BIN_ADDR_W-1:0] : t_bin_addr'(i_voxel);
        req.wr_en   = r_s1_vld;
        req.wr_addr = r_s1_addr;
        req.wr_data = new_cnt;
        req.clr_all = scan_done;
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_RUN:   if (i_cnt_acc && i_last) n_st = ST_DRAIN;
            ST_DRAIN: n_st = ST_SCAN;
            ST_SCAN:  if (scan_done) n_st = ST_RUN;
            default:  n_st = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_RUN;
            r_s1_vld <= 1'b0;
            r_fw_vld <= 1'b0;
            r_sc_vld <= 1'b0;
            r_mode   <= '0;
            r_scan_addr <= '0;
        end else begin
            r_st     <= n_st;
            r_s1_vld <= i_cnt_acc;
            r_fw_vld <= r_s1_vld;
            r_sc_vld <= scan_issue;
            if (r_st != ST_SCAN) begin
                r_scan_addr <= '0;
            end else if (scan_issue) begin
                r_scan_addr <= r_scan_addr + (BIN_ADDR_W + 1)'(1);
            end
            if (scan_done) begin
                r_mode <= t_vox'(n_best_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= t_bin_addr'(i_voxel);
        r_fw_addr <= r_s1_addr;
        r_fw_data <= new_cnt;
        r_sc_idx  <= r_scan_addr[BIN_ADDR_W-1:0];
        if (take) begin
            r_best     <= rsp.rd_cnt;
            r_best_idx <= r_sc_idx;
        end
    end

    assign o_busy = (r_st != ST_RUN);
    assign o_mode = r_mode;

endmodule

`default_nettype wire

### rtl/core/hmbs_out_fifo.sv
// Two-entry result buffer: two registered slots with read and write pointers.
// Depends on hmbs_pkg and hmbs_out_if.
`timescale 1ns / 1ps
`default_nettype none

module hmbs_out_fifo (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  hmbs_pkg::t_vox  i_pixel,
    input  wire             i_last,
    output logic            o_full,
    hmbs_out_if.source      o_out
);
    import hmbs_pkg::*;

    t_vox       r_pix  [2];
    logic [1:0] r_lst;
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_pix[r_wptr] <= i_pixel;
            r_lst[r_wptr] <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (pop)    r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

    assign o_full          = r_cnt[1];
    assign o_out.valid     = (r_cnt != 2'd0);
    assign o_out.pixel_out = r_pix[r_rptr];
    assign o_out.last_out  = r_lst[r_rptr];

endmodule

`default_nettype wire

### rtl/core/histogram_mode_background_subtract_top.sv
// Top level of histogram mode background subtraction.
// Depends on hmbs_pkg, hmbs_if, hmbs_hist_ctrl and hmbs_out_fifo.
//
//  Channel  Dir  Payload                        Item moves when
//  i_in     in   kind, voxel, last_voxel        i_in.valid && i_in.ready
//  o_out    out  pixel_out, last_out            o_out.valid && o_out.ready
//
// Count-pass and subtract-pass items enter at one per cycle when ready.
// A count item reads its bin at acceptance and writes it back in the next
// cycle; the bin memory's single write port sets that rate, and
// back-to-back hits on one bin are forwarded. After a count item marked
// last, i_in.ready stays low to write the last bin, read every bin through
// the memory read port and compare the final bin. The histogram clears at
// once at the end of the scan, and at reset, through per-bin valid flops.
// Reset is synchronous, active low. A subtract result lands in a two-entry
// buffer, so input keeps flowing while one result waits on o_out.
`timescale 1ns / 1ps
`default_nettype none

module histogram_mode_background_subtract_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    hmbs_in_if.sink    i_in,
    hmbs_out_if.source o_out
);
    import hmbs_pkg::*;

    logic busy;
    logic full;
    logic acc;
    logic cnt_acc;
    logic sub_acc;
    t_vox mode;
    t_vox diff;

    // Hold input while the controller is busy or the result buffer is full.
    assign i_in.ready = !busy && !full;
    assign acc        = i_in.valid && i_in.ready;
    assign cnt_acc    = acc && !i_in.kind;
    assign sub_acc    = acc && i_in.kind;

    // Clamp the subtraction at zero.
    assign diff = (i_in.voxel > mode) ? (i_in.voxel - mode) : '0;

    hmbs_hist_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cnt_acc (cnt_acc),
        .i_voxel   (i_in.voxel),
        .i_last    (i_in.last_voxel),
        .o_busy    (busy),
        .o_mode    (mode)
    );

    hmbs_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (sub_acc),
        .i_pixel (diff),
        .i_last  (i_in.last_voxel),
        .o_full  (full),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    a_last_count_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cnt_acc && i_in.last_voxel) |=> (busy && !i_in.ready))
        else $error("scan did not start after last count item");

    a_sub_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sub_acc |=> o_out.valid)
        else $error("subtract item produced no result");

    a_mode_stable_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !$past(busy)) |-> $stable(mode))
        else $error("mode changed outside the scan");
`endif

endmodule

`default_nettype wire
